/* rtl/core/tll_pkg.sv */
// Shared types, constants and character-class functions for the template token lexer.
`timescale 1ns / 1ps

package tll_pkg;

  // Text length limit: the character at count MAX_TEXT_LEN - 1 closes the text.
  localparam int MAX_TEXT_LEN = 65536;
  localparam int CNT_W        = $clog2(MAX_TEXT_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TEXT_LEN - 1);

  // Result queue depth; it must hold the two tokens one character can cause.
  localparam int FIFO_DEPTH = 4;
  localparam int QPTR_W     = $clog2(FIFO_DEPTH);
  localparam int QCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Token kinds
  localparam logic [4:0] K_DATATYPE = 5'd0;
  localparam logic [4:0] K_PERCENT  = 5'd1;
  localparam logic [4:0] K_LBRACE   = 5'd2;
  localparam logic [4:0] K_RBRACE   = 5'd3;
  localparam logic [4:0] K_LPAREN   = 5'd4;
  localparam logic [4:0] K_RPAREN   = 5'd5;
  localparam logic [4:0] K_PLUS     = 5'd6;
  localparam logic [4:0] K_MINUS    = 5'd7;
  localparam logic [4:0] K_STAR     = 5'd8;
  localparam logic [4:0] K_SLASH    = 5'd9;
  localparam logic [4:0] K_EQ       = 5'd10;
  localparam logic [4:0] K_ARGREF   = 5'd11;
  localparam logic [4:0] K_VARIABLE = 5'd12;
  localparam logic [4:0] K_BANG     = 5'd13;
  localparam logic [4:0] K_GREAT    = 5'd14;
  localparam logic [4:0] K_LESS     = 5'd15;
  localparam logic [4:0] K_GREATEQ  = 5'd16;
  localparam logic [4:0] K_LESSEQ   = 5'd17;
  localparam logic [4:0] K_DQUOTE   = 5'd18;
  localparam logic [4:0] K_SQUOTE   = 5'd19;
  localparam logic [4:0] K_SEMI     = 5'd20;
  localparam logic [4:0] K_EQUALS   = 5'd21;
  localparam logic [4:0] K_SPACE    = 5'd22;
  localparam logic [4:0] K_MAX      = K_SPACE;
  localparam logic [4:0] K_ORDINARY = 5'd31;

  // Scan modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_VAR  = 3'd1;
  localparam logic [2:0] M_PCT  = 3'd2;
  localparam logic [2:0] M_DT   = 3'd3;
  localparam logic [2:0] M_ARG  = 3'd4;

  // Held lead characters
  localparam logic [1:0] L_NONE  = 2'd0;
  localparam logic [1:0] L_EQ    = 2'd1;
  localparam logic [1:0] L_GREAT = 2'd2;
  localparam logic [1:0] L_LESS  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last_run;
    logic        eot;
  } tok_t;

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c) inside
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_BANG:   k = K_BANG;
      CH_DQUOTE: k = K_DQUOTE;
      CH_SQUOTE: k = K_SQUOTE;
      CH_SEMI:   k = K_SEMI;
      CH_SP, CH_TAB, CH_LF, CH_VT, CH_CR, CH_FF: k = K_SPACE;
      default:   k = K_ORDINARY;
    endcase
    return k;
  endfunction

  function automatic logic is_ordinary(input logic [7:0] c);
    return (c != CH_PCT) && (c != CH_DOLLAR) && (c != CH_EQ) && (c != CH_GT) &&
           (c != CH_LT) && (single_kind(c) == K_ORDINARY);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [4:0] lead_single(input logic [1:0] lead);
    logic [4:0] k;
    case (lead)
      L_GREAT: k = K_GREAT;
      L_LESS:  k = K_LESS;
      default: k = K_EQUALS;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] lead_double(input logic [1:0] lead);
    logic [4:0] k;
    case (lead)
      L_GREAT: k = K_GREATEQ;
      L_LESS:  k = K_LESSEQ;
      default: k = K_EQ;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/template_token_lexer.sv */
// Top level of the template token lexer: scan state, step logic and result queue.
`timescale 1ns / 1ps

// Template token lexer. Feed one character of a text per item on s_axis (tlast marks the
// last character of the text); tokens leave on m_axis as one item each, with start offset
// and length in tdata, kind and a last-of-character flag in tuser, and tlast on the final
// token of the text. A character is taken in the cycle it arrives: the scan state lives in
// a few registers and the whole step (close the open token, start the next one, flush on
// the last character) is one level of shallow logic that writes straight into a 4-entry
// token queue, so with the queue empty its first token shows on m_axis in the next cycle.
// A character is taken whenever the queue can take two tokens. The output port drains one
// token per clock while m_axis_tready is high, and a character that gives two tokens
// always closes what was open and leaves nothing open, so a text never produces more than
// about one token per character: with m_axis always ready the queue holds two tokens at
// most and characters flow at one per clock. Only output stalls fill the queue and drop
// s_axis_tready. Characters inside a variable, datatype or argument run produce no token.
// A text longer than 65535 characters is closed after its 65536th character, and offsets
// and lengths wrap modulo 2^16.
module template_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
  output logic [5:0]  m_axis_tuser,   // [4:0] token_kind, [5] last_of_run
  output logic        m_axis_tlast    // end_of_text
);

  // Scan state
  logic [2:0]                  mode, mode_next;
  logic [1:0]                  lead, lead_next;
  logic [15:0]                 run_start, run_start_next;
  logic [15:0]                 position, position_next;
  logic [tll_pkg::CNT_W-1:0]   text_cnt, text_cnt_next;

  // Step logic intermediates
  logic                        accept;
  logic                        final_c;
  logic                        handled;
  logic [15:0]                 next_pos, prev_pos;
  logic [2:0]                  mode_a, mode_b;
  logic [1:0]                  lead_a, lead_b;
  logic [15:0]                 rs_b;
  tll_pkg::tok_t               e1, e2, e3;
  logic                        e1v, e2v, e3v;
  tll_pkg::tok_t               slot0, slot1;
  logic [1:0]                  tok_n;

  // Token queue
  tll_pkg::tok_t               fifo [tll_pkg::FIFO_DEPTH];
  logic [tll_pkg::QPTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [tll_pkg::QPTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [tll_pkg::QCNT_W-1:0]  count, count_next;
  logic [1:0]                  wr_n;
  logic                        rd;
  tll_pkg::tok_t               head;

  // Take a character only when the queue has room for the two tokens it may cause.
  assign s_axis_tready = (count <= tll_pkg::QCNT_W'(tll_pkg::FIFO_DEPTH - 2));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // A text that reaches the length limit is closed as if tlast were set.
    final_c  = s_axis_tlast || (text_cnt == tll_pkg::CNT_LAST);
    next_pos = position + 16'd1;
    prev_pos = position - 16'd1;
    handled  = 1'b0;
    mode_a   = mode;
    lead_a   = lead;
    e1       = '0;
    e2       = '0;
    e3       = '0;
    e1v      = 1'b0;
    e2v      = 1'b0;
    e3v      = 1'b0;

    // Close whatever the previous character left open.
    if (lead != tll_pkg::L_NONE) begin
      e1v      = 1'b1;
      e1.start = prev_pos;
      if (s_axis_tdata == tll_pkg::CH_EQ) begin
        e1.kind   = tll_pkg::lead_double(lead);
        e1.length = 16'd2;
        handled   = 1'b1;
      end else begin
        e1.kind   = tll_pkg::lead_single(lead);
        e1.length = 16'd1;
      end
      lead_a = tll_pkg::L_NONE;
    end else begin
      unique case (mode)
        tll_pkg::M_VAR: begin
          if (tll_pkg::is_ordinary(s_axis_tdata)) begin
            handled = 1'b1;
          end else begin
            e1v       = 1'b1;
            e1.kind   = tll_pkg::K_VARIABLE;
            e1.start  = run_start;
            e1.length = position - run_start;
            mode_a    = tll_pkg::M_IDLE;
          end
        end
        tll_pkg::M_PCT: begin
          if (s_axis_tdata == tll_pkg::CH_PCT) begin
            e1v       = 1'b1;
            e1.kind   = tll_pkg::K_PERCENT;
            e1.start  = prev_pos;
            e1.length = 16'd2;
            mode_a    = tll_pkg::M_IDLE;
            handled   = 1'b1;
          end else if (tll_pkg::is_letter(s_axis_tdata)) begin
            mode_a  = tll_pkg::M_DT;
            handled = 1'b1;
          end else begin
            // Empty datatype right after the percent sign.
            e1v       = 1'b1;
            e1.kind   = tll_pkg::K_DATATYPE;
            e1.start  = run_start;
            e1.length = 16'd0;
            mode_a    = tll_pkg::M_IDLE;
          end
        end
        tll_pkg::M_DT: begin
          if (tll_pkg::is_letter(s_axis_tdata)) begin
            handled = 1'b1;
          end else begin
            e1v       = 1'b1;
            e1.kind   = tll_pkg::K_DATATYPE;
            e1.start  = run_start;
            e1.length = position - run_start;
            mode_a    = tll_pkg::M_IDLE;
          end
        end
        tll_pkg::M_ARG: begin
          if (tll_pkg::is_digit(s_axis_tdata)) begin
            handled = 1'b1;
          end else begin
            e1v       = 1'b1;
            e1.kind   = tll_pkg::K_ARGREF;
            e1.start  = run_start;
            e1.length = position - run_start;
            mode_a    = tll_pkg::M_IDLE;
          end
        end
        default: mode_a = tll_pkg::M_IDLE;
      endcase
    end

    // Start on the current character unless it already extended or closed a token.
    mode_b = mode_a;
    lead_b = lead_a;
    rs_b   = run_start;
    if (!handled) begin
      if (s_axis_tdata == tll_pkg::CH_PCT) begin
        mode_b = tll_pkg::M_PCT;
        rs_b   = next_pos;
      end else if (s_axis_tdata == tll_pkg::CH_DOLLAR) begin
        mode_b = tll_pkg::M_ARG;
        rs_b   = next_pos;
      end else if (s_axis_tdata == tll_pkg::CH_EQ) begin
        lead_b = tll_pkg::L_EQ;
      end else if (s_axis_tdata == tll_pkg::CH_GT) begin
        lead_b = tll_pkg::L_GREAT;
      end else if (s_axis_tdata == tll_pkg::CH_LT) begin
        lead_b = tll_pkg::L_LESS;
      end else if (tll_pkg::single_kind(s_axis_tdata) != tll_pkg::K_ORDINARY) begin
        e2v       = 1'b1;
        e2.kind   = tll_pkg::single_kind(s_axis_tdata);
        e2.start  = position;
        e2.length = 16'd1;
      end else begin
        mode_b = tll_pkg::M_VAR;
        rs_b   = position;
      end
    end

    // Flush the open token on the last character of the text.
    if (final_c) begin
      if (lead_b != tll_pkg::L_NONE) begin
        e3v       = 1'b1;
        e3.kind   = tll_pkg::lead_single(lead_b);
        e3.start  = position;
        e3.length = 16'd1;
      end else begin
        unique case (mode_b)
          tll_pkg::M_VAR: begin
            e3v       = 1'b1;
            e3.kind   = tll_pkg::K_VARIABLE;
            e3.start  = rs_b;
            e3.length = next_pos - rs_b;
          end
          tll_pkg::M_PCT: begin
            e3v       = 1'b1;
            e3.kind   = tll_pkg::K_DATATYPE;
            e3.start  = rs_b;
            e3.length = 16'd0;
          end
          tll_pkg::M_DT: begin
            e3v       = 1'b1;
            e3.kind   = tll_pkg::K_DATATYPE;
            e3.start  = rs_b;
            e3.length = next_pos - rs_b;
          end
          tll_pkg::M_ARG: begin
            e3v       = 1'b1;
            e3.kind   = tll_pkg::K_ARGREF;
            e3.start  = rs_b;
            e3.length = next_pos - rs_b;
          end
          default: e3v = 1'b0;
        endcase
      end
    end

    // Pack the tokens in order. At most two exist: a single-character token from the
    // start phase leaves nothing open for the flush.
    tok_n = 2'({1'b0, e1v} + {1'b0, e2v} + {1'b0, e3v});
    slot0 = e1v ? e1 : (e2v ? e2 : e3);
    slot1 = e2v ? e2 : e3;
    if (tok_n == 2'd1) begin
      slot0.last_run = 1'b1;
      slot0.eot      = final_c;
    end
    if (tok_n == 2'd2) begin
      slot1.last_run = 1'b1;
      slot1.eot      = final_c;
    end

    // Advance the scan state; the end of a text returns it to its reset value.
    mode_next      = mode;
    lead_next      = lead;
    run_start_next = run_start;
    position_next  = position;
    text_cnt_next  = text_cnt;
    if (accept) begin
      if (final_c) begin
        mode_next      = tll_pkg::M_IDLE;
        lead_next      = tll_pkg::L_NONE;
        run_start_next = '0;
        position_next  = '0;
        text_cnt_next  = '0;
      end else begin
        mode_next      = mode_b;
        lead_next      = lead_b;
        run_start_next = rs_b;
        position_next  = next_pos;
        text_cnt_next  = text_cnt + tll_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= tll_pkg::M_IDLE;
      lead      <= tll_pkg::L_NONE;
      run_start <= '0;
      position  <= '0;
      text_cnt  <= '0;
    end else begin
      mode      <= mode_next;
      lead      <= lead_next;
      run_start <= run_start_next;
      position  <= position_next;
      text_cnt  <= text_cnt_next;
    end
  end

  // Token queue: up to two writes and one read per cycle.
  assign wr_n        = accept ? tok_n : 2'd0;
  assign rd          = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_next = wr_ptr + tll_pkg::QPTR_W'(wr_n);
  assign rd_ptr_next = rd_ptr + tll_pkg::QPTR_W'(rd);
  assign count_next  = count + tll_pkg::QCNT_W'(wr_n) - tll_pkg::QCNT_W'(rd);

  always_ff @(posedge clk) begin
    if (accept && (tok_n != 2'd0)) begin
      fifo[wr_ptr] <= slot0;
    end
    if (accept && (tok_n == 2'd2)) begin
      fifo[wr_ptr + tll_pkg::QPTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Present the oldest token.
  assign head          = fifo[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {head.length, head.start};
  assign m_axis_tuser  = {head.last_run, head.kind};
  assign m_axis_tlast  = head.eot;

endmodule

/* rtl/core/tll_checker.sv */
// Port-level checks for the template token lexer and their binding to it.
`timescale 1ns / 1ps

module tll_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [5:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled token.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled token changed");

  // The final token of a text also closes its character's tokens.
  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[5])
    else $error("end of text without last-of-run");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[4:0] <= tll_pkg::K_MAX))
    else $error("token kind out of range");

  // Two-character operators always cover exactly two characters.
  a_pair_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((m_axis_tuser[4:0] == tll_pkg::K_PERCENT) ||
      (m_axis_tuser[4:0] == tll_pkg::K_EQ) || (m_axis_tuser[4:0] == tll_pkg::K_GREATEQ) ||
      (m_axis_tuser[4:0] == tll_pkg::K_LESSEQ)) |-> (m_axis_tdata[31:16] == 16'd2))
    else $error("pair token with wrong length");

  // Come out of reset with an empty queue, ready for the first character.
  a_ready_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("block not empty after reset");

endmodule

bind template_token_lexer tll_checker u_tll_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
